// File: hdl/tat_pkg.sv
// Shared types and constants for the tag attribute tokenizer.
// No dependencies; every other file in hdl/ refers to this package.
package tat_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int CFG_BITS    = 16;
  localparam int CMP_BITS    = (LENGTH_BITS > CFG_BITS) ? LENGTH_BITS : CFG_BITS;

  localparam logic [CFG_BITS-1:0] MAX_LEN_RESET = 16'd4096;

  typedef logic [7:0]             byte_t;
  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [CFG_BITS-1:0]    cfg_t;

  typedef enum logic [3:0] {
    ROLE_OUTSIDE   = 4'd0,
    ROLE_OPEN      = 4'd1,
    ROLE_CMD_CHAR  = 4'd2,
    ROLE_SPACE     = 4'd3,
    ROLE_ATTR_CHAR = 4'd4,
    ROLE_FLAG_END  = 4'd5,
    ROLE_EQUALS    = 4'd6,
    ROLE_QUOTE     = 4'd7,
    ROLE_VAL_CHAR  = 4'd8,
    ROLE_VAL_END   = 4'd9,
    ROLE_COMPLETE  = 4'd10,
    ROLE_SLASH     = 4'd11,
    ROLE_ABANDON   = 4'd12,
    ROLE_OVERFLOW  = 4'd13
  } role_t;

  localparam byte_t CH_LT    = 8'h3C;  // <
  localparam byte_t CH_GT    = 8'h3E;  // >
  localparam byte_t CH_SLASH = 8'h2F;  // /
  localparam byte_t CH_EQ    = 8'h3D;  // =
  localparam byte_t CH_USCORE = 8'h5F; // _
  localparam byte_t CH_SQUOTE = 8'h27; // '
  localparam byte_t CH_DQUOTE = 8'h22; // "
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_CR    = 8'h0D;

endpackage

// File: hdl/tat_in_if.sv
// Input byte channel: valid/ready handshake carrying one received character.
// Depends on tat_pkg.
interface tat_in_if;
  logic           valid;
  logic           ready;
  tat_pkg::byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// File: hdl/tat_out_if.sv
// Result channel: valid/ready handshake carrying a byte and its role code.
// Depends on tat_pkg.
interface tat_out_if;
  logic           valid;
  logic           ready;
  tat_pkg::byte_t byte_out;
  tat_pkg::role_t role;

  modport source (output valid, output byte_out, output role, input ready);
  modport sink   (input valid, input byte_out, input role, output ready);
endinterface

// File: hdl/tag_attribute_tokenizer.sv
// Tag attribute tokenizer: tags each received byte with its role in a start tag.
// Input register loads on accept; result register loads when stage 1 advances.
// Throughput: 1 item per cycle while the output is not stalled; the phase
// update in the classify stage sets the rate. Output stalls back up through
// ready.
// Reset (rst_n, synchronous): phase searching for '<', quote 0, length 0,
// limit 4096, both pipeline stages empty. Depends on tat_pkg, tat_in_if, tat_out_if.
module tag_attribute_tokenizer (
  input  logic                 clk,
  input  logic                 rst_n,
  tat_in_if.sink               in_if,
  tat_out_if.source            out_if,
  input  logic                 cfg_wr_en,
  input  tat_pkg::cfg_t        cfg_wr_data
);

  // Parse phases; code 7 is unused and behaves like PH_FIND.
  typedef enum logic [2:0] {
    PH_FIND  = 3'd0,
    PH_CMD   = 3'd1,
    PH_TOKEN = 3'd2,
    PH_SLASH = 3'd3,
    PH_ATTR  = 3'd4,
    PH_QUOTE = 3'd5,
    PH_VALUE = 3'd6
  } phase_t;

  typedef struct packed {
    phase_t         phase;
    tat_pkg::role_t role;
  } step_t;

  localparam tat_pkg::len_t LEN_SAT = {tat_pkg::LENGTH_BITS{1'b1}};

  function automatic logic is_letter(input tat_pkg::byte_t c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_blank(input tat_pkg::byte_t c);
    return (c == tat_pkg::CH_SPACE) || (c >= tat_pkg::CH_TAB && c <= tat_pkg::CH_CR);
  endfunction

  // Byte seen between tokens; a misfit abandons the tag, '<' reopens one.
  function automatic step_t token_step(input tat_pkg::byte_t c);
    step_t s;
    if (is_blank(c)) begin
      s = '{PH_TOKEN, tat_pkg::ROLE_SPACE};
    end else if (is_letter(c)) begin
      s = '{PH_ATTR, tat_pkg::ROLE_ATTR_CHAR};
    end else if (c == tat_pkg::CH_GT) begin
      s = '{PH_FIND, tat_pkg::ROLE_COMPLETE};
    end else if (c == tat_pkg::CH_SLASH) begin
      s = '{PH_SLASH, tat_pkg::ROLE_SLASH};
    end else if (c == tat_pkg::CH_LT) begin
      s = '{PH_CMD, tat_pkg::ROLE_OPEN};
    end else begin
      s = '{PH_FIND, tat_pkg::ROLE_ABANDON};
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Pipeline control: stage 1 holds the accepted byte, stage 2 the result.
  // ---------------------------------------------------------------------
  logic           s1_valid_r;
  tat_pkg::byte_t s1_byte_r;
  logic           out_valid_r;
  tat_pkg::byte_t out_byte_r;
  tat_pkg::role_t out_role_r;
  logic           advance;
  logic           in_fire;

  assign advance  = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;
  assign in_fire  = in_if.valid && in_if.ready;

  assign out_if.valid    = out_valid_r;
  assign out_if.byte_out = out_byte_r;
  assign out_if.role     = out_role_r;

  // ---------------------------------------------------------------------
  // Tokenizer state
  // ---------------------------------------------------------------------
  phase_t         phase_r, phase_nxt;
  tat_pkg::byte_t quote_r, quote_nxt;
  tat_pkg::len_t  len_r,   len_nxt;
  tat_pkg::cfg_t  max_len_r;
  tat_pkg::role_t role_nxt;

  // Classify one byte. Chains like attr name -> between tokens, or
  // value start -> value char, resolve in the same cycle.
  always_comb begin
    step_t          s;
    tat_pkg::byte_t c;
    tat_pkg::len_t  len_tmp;
    logic           quoted_end;
    c         = s1_byte_r;
    quote_nxt = quote_r;
    quoted_end = 1'b0;
    case (phase_r)
      PH_CMD: begin
        if (is_letter(c) || c == tat_pkg::CH_USCORE) begin
          s = '{PH_CMD, tat_pkg::ROLE_CMD_CHAR};
        end else begin
          s = token_step(c);
        end
      end
      PH_TOKEN: s = token_step(c);
      PH_SLASH: begin
        if (c == tat_pkg::CH_GT) begin
          s = '{PH_FIND, tat_pkg::ROLE_COMPLETE};
        end else if (c == tat_pkg::CH_LT) begin
          s = '{PH_CMD, tat_pkg::ROLE_OPEN};
        end else begin
          s = '{PH_FIND, tat_pkg::ROLE_ABANDON};
        end
      end
      PH_ATTR: begin
        if (is_letter(c)) begin
          s = '{PH_ATTR, tat_pkg::ROLE_ATTR_CHAR};
        end else if (c == tat_pkg::CH_EQ) begin
          s = '{PH_QUOTE, tat_pkg::ROLE_EQUALS};
        end else if (is_blank(c)) begin
          s = '{PH_TOKEN, tat_pkg::ROLE_FLAG_END};
        end else begin
          s = token_step(c);  // name dropped, byte re-examined
        end
      end
      PH_QUOTE: begin
        if (c == tat_pkg::CH_SQUOTE || c == tat_pkg::CH_DQUOTE) begin
          quote_nxt = c;
          s = '{PH_VALUE, tat_pkg::ROLE_QUOTE};
        end else begin
          // unquoted value: this byte is already its first char
          quote_nxt = '0;
          if (is_blank(c)) begin
            s = '{PH_TOKEN, tat_pkg::ROLE_VAL_END};
          end else begin
            s = '{PH_VALUE, tat_pkg::ROLE_VAL_CHAR};
          end
        end
      end
      PH_VALUE: begin
        quoted_end = (quote_r != '0) ? (c == quote_r) : is_blank(c);
        if (quoted_end) begin
          s = '{PH_TOKEN, tat_pkg::ROLE_VAL_END};
        end else begin
          s = '{PH_VALUE, tat_pkg::ROLE_VAL_CHAR};
        end
      end
      default: begin
        if (c == tat_pkg::CH_LT) begin
          s = '{PH_CMD, tat_pkg::ROLE_OPEN};
        end else begin
          s = '{PH_FIND, tat_pkg::ROLE_OUTSIDE};
        end
      end
    endcase

    // Tag length: restart on '<', saturating count inside a tag.
    if (s.role == tat_pkg::ROLE_OPEN) begin
      len_tmp = tat_pkg::len_t'(1);
    end else if (s.phase != PH_FIND) begin
      len_tmp = (len_r != LEN_SAT) ? len_r + tat_pkg::len_t'(1) : len_r;
    end else begin
      len_tmp = '0;
    end

    // Drop an unfinished tag that has reached the limit.
    if (s.phase != PH_FIND &&
        tat_pkg::CMP_BITS'(len_tmp) >= tat_pkg::CMP_BITS'(max_len_r)) begin
      phase_nxt = PH_FIND;
      role_nxt  = tat_pkg::ROLE_OVERFLOW;
      len_nxt   = '0;
    end else begin
      phase_nxt = s.phase;
      role_nxt  = s.role;
      len_nxt   = len_tmp;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_FIND;
      quote_r     <= '0;
      len_r       <= '0;
      max_len_r   <= tat_pkg::MAX_LEN_RESET;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        quote_r     <= quote_nxt;
        len_r       <= len_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_if.data_byte;
    end
    if (advance) begin
      out_byte_r <= s1_byte_r;
      out_role_r <= role_nxt;
    end
  end

endmodule
